// File: sv/dtf_pkg.sv
// Package for the damped target follower: fixed constants, register indexes,
// configuration and shared-unit control types. No dependencies.

package dtf_pkg;

    // time step dt = 6554 / 65536 (about 0.1)
    localparam int unsigned DT_NUM      = 6554;
    localparam int unsigned DT_SHIFT    = 16;
    localparam int unsigned DECAY_SHIFT = 8;

    // coefficient width into the shared multiplier (covers DT_NUM and decay)
    localparam int unsigned COEF_W = 13;

    localparam int unsigned DECAY_W = 11;
    localparam int unsigned MODE_W  = 2;

    localparam logic [DECAY_W-1:0] DECAY_FLOOR = 11'd26;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 11'd154;

    // damping modes
    localparam logic [MODE_W-1:0] MODE_DOUBLE0 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPRING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DOUBLE3 = 2'd3;

    // register indexes
    localparam logic REG_DECAY = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    typedef struct packed {
        logic [DECAY_W-1:0] decay;
        logic [MODE_W-1:0]  mode;
    } cfg_t;

    // control word for the shared multiply-round unit
    typedef struct packed {
        logic load;     // capture a new product this cycle
        logic use_dt;   // 1: scale by dt, 0: scale by decay
    } mul_op_t;

endpackage

// File: sv/dtf_regs.sv
// Configuration register file for the damped target follower (APB-style port).
// Depends on dtf_pkg.

module dtf_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dtf_pkg::cfg_t       cfg
);

    logic [dtf_pkg::DECAY_W-1:0] decay_reg, decay_next;
    logic [dtf_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [dtf_pkg::DECAY_W-1:0] wr_decay;
    logic                        wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite;
    assign wr_decay = pwdata[dtf_pkg::DECAY_W-1:0];

    always_comb begin
        decay_next = decay_reg;
        mode_next  = mode_reg;
        if (wr_en) begin
            case (paddr[2])
                dtf_pkg::REG_DECAY: begin
                    // raise writes below the floor
                    decay_next = (wr_decay < dtf_pkg::DECAY_FLOOR) ? dtf_pkg::DECAY_FLOOR
                                                                   : wr_decay;
                end
                dtf_pkg::REG_MODE: begin
                    mode_next = pwdata[dtf_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= dtf_pkg::DECAY_RESET;
            mode_reg  <= dtf_pkg::MODE_DOUBLE0;
        end else begin
            decay_reg <= decay_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb begin
        case (paddr[2])
            dtf_pkg::REG_DECAY: prdata = {{(32-dtf_pkg::DECAY_W){1'b0}}, decay_reg};
            dtf_pkg::REG_MODE:  prdata = {{(32-dtf_pkg::MODE_W){1'b0}}, mode_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.decay = decay_reg;
    assign cfg.mode  = mode_reg;

endmodule

// File: sv/dtf_mul.sv
// Shared multiply-and-round unit: y = round(a * coef / 2^shift), coef is dt or decay.
// Rounds to nearest, ties toward plus infinity. Depends on dtf_pkg.

module dtf_mul #(
    parameter int AW = 22
) (
    input  logic                         aclk,
    input  dtf_pkg::mul_op_t             op,
    input  logic signed [AW-1:0]         a,
    input  logic [dtf_pkg::DECAY_W-1:0]  decay,
    output logic signed [AW-1:0]         y
);

    localparam int PW = AW + dtf_pkg::COEF_W + 1;

    logic [dtf_pkg::COEF_W-1:0] coef;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       sum_dt, sum_dc;
    logic signed [PW-1:0]       shifted;
    logic signed [AW-1:0]       y_reg;

    assign coef = op.use_dt ? dtf_pkg::COEF_W'(dtf_pkg::DT_NUM)
                            : {{(dtf_pkg::COEF_W-dtf_pkg::DECAY_W){1'b0}}, decay};

    assign prod   = PW'(a) * $signed({1'b0, coef});
    assign sum_dt = prod + (PW'(1) <<< (dtf_pkg::DT_SHIFT - 1));
    assign sum_dc = prod + (PW'(1) <<< (dtf_pkg::DECAY_SHIFT - 1));

    // arithmetic shift gives floor, which with the half added is the rounding wanted
    assign shifted = op.use_dt ? (sum_dt >>> dtf_pkg::DT_SHIFT)
                               : (sum_dc >>> dtf_pkg::DECAY_SHIFT);

    always_ff @(posedge aclk) begin
        if (op.load) begin
            y_reg <= shifted[AW-1:0];
        end
    end

    assign y = y_reg;

endmodule

// File: sv/damped_target_follower.sv
// Damped target follower: one target word in, one clamped level word out.
// Each accepted target runs steps M1, M2 and, in the spring-damper and doubled-gain modes, M3
// on one shared multiplier; the position step then registers the clamped level and result valid.
// A new word is taken only in idle, once the last is through; a waiting result holds the last step.
// Reset: synchronous active-low aresetn; position 0, velocity 0.1, decay 154, mode 0.
// Depends on dtf_pkg, dtf_regs, dtf_mul.

module damped_target_follower #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((FRAC_BITS+1+7)/8)*8-1:0]      s_tdata,   // [FRAC_BITS:0] target
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((FRAC_BITS+1+7)/8)*8-1:0]      m_tdata,   // [FRAC_BITS:0] level
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    // position / target width, velocity width, working width of the shared unit
    localparam int PW = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS + 3;
    localparam int AW = FRAC_BITS + 8;
    localparam int DW = ((PW + 7) / 8) * 8;
    localparam int VEL_RESET_I = ((1 << FRAC_BITS) + 5) / 10;

    localparam logic [VW-1:0]        VEL_RESET = VW'(VEL_RESET_I);
    localparam logic signed [AW-1:0] ONE_A     = AW'(1) <<< FRAC_BITS;

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M1   = 3'd1;
    localparam logic [2:0] ST_M2   = 3'd2;
    localparam logic [2:0] ST_M3   = 3'd3;
    localparam logic [2:0] ST_POS  = 3'd4;

    dtf_pkg::cfg_t     cfg;
    dtf_pkg::mul_op_t  mul_op;

    logic [2:0]              state_reg, state_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic signed [VW-1:0]    vel_reg, vel_next;
    logic signed [AW-1:0]    err_reg, err_next;
    logic [PW-1:0]           level_reg, level_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    logic signed [AW-1:0]    mul_a;
    logic signed [AW-1:0]    mul_y;
    logic signed [AW-1:0]    vel_sum;
    logic signed [VW-1:0]    vel_sat_prod, vel_sat_sum;
    logic signed [AW-1:0]    pos_sum;
    logic [PW-1:0]           pos_clamped;
    logic                    out_free;
    logic                    spring;

    // saturate a working-width value to the velocity range -4.0 .. 4.0 - lsb
    function automatic logic signed [VW-1:0] sat_vel(input logic signed [AW-1:0] v);
        logic hi_all1;
        logic hi_all0;
        hi_all1 = &v[AW-1:VW-1];
        hi_all0 = ~|v[AW-1:VW-1];
        if (hi_all1 || hi_all0) begin
            sat_vel = v[VW-1:0];
        end else if (v[AW-1]) begin
            sat_vel = {1'b1, {(VW-1){1'b0}}};
        end else begin
            sat_vel = {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    dtf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtf_mul #(
        .AW (AW)
    ) u_mul (
        .aclk  (aclk),
        .op    (mul_op),
        .a     (mul_a),
        .decay (cfg.decay),
        .y     (mul_y)
    );

    assign spring   = (cfg.mode == dtf_pkg::MODE_SPRING);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);

    // candidate velocities: straight from a product, or velocity plus a product
    assign vel_sat_prod = sat_vel(mul_y);
    assign vel_sum      = AW'(vel_reg) + mul_y;
    assign vel_sat_sum  = sat_vel(vel_sum);

    // new position, clamped to 0 .. 1.0
    assign pos_sum = $signed({{(AW-PW){1'b0}}, pos_reg}) + mul_y;
    always_comb begin
        if (pos_sum[AW-1]) begin
            pos_clamped = '0;
        end else if (pos_sum > ONE_A) begin
            pos_clamped = ONE_A[PW-1:0];
        end else begin
            pos_clamped = pos_sum[PW-1:0];
        end
    end

    // sequencer: pick the multiplier operand and scale for each step
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        vel_next      = vel_reg;
        err_next      = err_reg;
        level_next    = level_reg;
        m_tvalid_next = m_tvalid_reg;
        mul_op.load   = 1'b0;
        mul_op.use_dt = 1'b0;
        mul_a         = err_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // take the error against the current position
                if (s_tvalid) begin
                    err_next   = $signed({{(AW-PW){1'b0}}, s_tdata[PW-1:0]})
                               - $signed({{(AW-PW){1'b0}}, pos_reg});
                    state_next = ST_M1;
                end
            end
            ST_M1: begin
                // spring: velocity*decay, else error*decay
                mul_op.load   = 1'b1;
                mul_op.use_dt = 1'b0;
                mul_a         = spring ? AW'(vel_reg) : err_reg;
                state_next    = ST_M2;
            end
            ST_M2: begin
                mul_op.load   = 1'b1;
                mul_op.use_dt = 1'b1;
                if (spring) begin
                    // acceleration times dt
                    mul_a      = err_reg - mul_y;
                    state_next = ST_M3;
                end else begin
                    // commit saturated velocity, then velocity times dt
                    vel_next   = vel_sat_prod;
                    mul_a      = AW'(vel_sat_prod);
                    state_next = (cfg.mode == dtf_pkg::MODE_PROP) ? ST_POS : ST_M3;
                end
            end
            ST_M3: begin
                mul_op.load = 1'b1;
                if (spring) begin
                    // integrate velocity, then velocity times dt
                    vel_next      = vel_sat_sum;
                    mul_a         = AW'(vel_sat_sum);
                    mul_op.use_dt = 1'b1;
                end else begin
                    // doubled gain: apply decay to the step once more
                    mul_a         = mul_y;
                    mul_op.use_dt = 1'b0;
                end
                state_next = ST_POS;
            end
            ST_POS: begin
                // hold until the output register is free
                if (out_free) begin
                    pos_next      = pos_clamped;
                    level_next    = pos_clamped;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            vel_reg      <= VEL_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            vel_reg      <= vel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg   <= err_next;
        level_reg <= level_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(DW-PW){1'b0}}, level_reg};

endmodule

// File: dv/testbench.sv
// Self-checking bench for damped_target_follower: target words in, damped level words out.
// Predicts each level in fixed point, checks it against the block; APB register writes between phases.
// Depends on dtf_pkg and the damped_target_follower RTL.

module testbench;

    localparam int FRAC_BITS = 14;
    localparam int TDATA_W   = ((FRAC_BITS + 1 + 7) / 8) * 8;
    localparam int LEVEL_W   = FRAC_BITS + 1;
    localparam int MAX_CYCLES = 400000;

    localparam longint ONE_LEVEL = longint'(1) << FRAC_BITS;
    localparam longint VEL_TOP   = (longint'(4) << FRAC_BITS) - 1;
    localparam longint VEL_BOTTOM = -(longint'(4) << FRAC_BITS);
    localparam longint VEL_START = (ONE_LEVEL + 5) / 10;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;    // [14:0] target
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;    // [14:0] level
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    damped_target_follower #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted follower state and register copy
    longint                       follow_pos;
    longint                       follow_vel;
    logic [dtf_pkg::DECAY_W-1:0]  cfg_decay;
    logic [dtf_pkg::MODE_W-1:0]   cfg_mode;

    logic [LEVEL_W-1:0]  target_queue [$];   // targets waiting to be offered
    logic [LEVEL_W-1:0]  level_expect [$];   // predicted levels, oldest first

    int  mismatches;
    int  cycles;

    // flow control, set by the sequence at the falling edge only
    bit  idle_enable;
    bit  src_pause;
    bit  hold_request;

    int  src_idle;
    int  sink_idle;
    int  hold_left;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("%0t: run limit reached", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // divide by 2^s, round to nearest with ties toward plus infinity
    function automatic longint round_down_shift(longint v, int unsigned s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint scale_dt(longint v);
        return round_down_shift(v * longint'(dtf_pkg::DT_NUM), dtf_pkg::DT_SHIFT);
    endfunction

    function automatic longint scale_decay(longint v);
        return round_down_shift(v * longint'(cfg_decay), dtf_pkg::DECAY_SHIFT);
    endfunction

    function automatic longint clamp_vel(longint v);
        if (v > VEL_TOP) return VEL_TOP;
        if (v < VEL_BOTTOM) return VEL_BOTTOM;
        return v;
    endfunction

    // advance the follower by one tick and return the new level
    function automatic logic [LEVEL_W-1:0] advance_follower(logic [LEVEL_W-1:0] target);
        longint err;
        longint accel;
        err = longint'(target) - follow_pos;
        case (cfg_mode)
            dtf_pkg::MODE_SPRING: begin
                accel = err - scale_decay(follow_vel);
                follow_vel = clamp_vel(follow_vel + scale_dt(accel));
                follow_pos += scale_dt(follow_vel);
            end
            dtf_pkg::MODE_PROP: begin
                follow_vel = clamp_vel(scale_decay(err));
                follow_pos += scale_dt(follow_vel);
            end
            default: begin
                // doubled gain: decay applied again to the step
                follow_vel = clamp_vel(scale_decay(err));
                follow_pos += scale_decay(scale_dt(follow_vel));
            end
        endcase
        if (follow_pos < 0)
            follow_pos = 0;
        else if (follow_pos > ONE_LEVEL)
            follow_pos = ONE_LEVEL;
        return follow_pos[LEVEL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offer queued targets, predict on every accepted word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_idle = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                level_expect.push_back(advance_follower(s_tdata[LEVEL_W-1:0]));
                offer = 1'b0;
            end
            // hold the current word until taken; only then pick the next one
            if (!offer) begin
                if (src_idle > 0) begin
                    src_idle--;
                end else if (target_queue.size() != 0 && !src_pause) begin
                    if (idle_enable && $urandom_range(0, 5) == 0) begin
                        src_idle = $urandom_range(1, 18) - 1;
                    end else begin
                        s_tdata <= TDATA_W'(target_queue.pop_front());
                        offer = 1'b1;
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted level word, drive back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic               ready;
        logic [LEVEL_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_idle = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_expect.size() == 0) begin
                    $display("%0t: unexpected level word, expected none, got %0d",
                             $time, m_tdata[LEVEL_W-1:0]);
                    mismatches++;
                end else begin
                    want = level_expect.pop_front();
                    if (m_tdata[LEVEL_W-1:0] !== want) begin
                        $display("%0t: level mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata[LEVEL_W-1:0]);
                        mismatches++;
                    end
                end
            end
            // a long hold-off lets the block fill up and stall its input
            if (hold_request) begin
                hold_left = 150;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (sink_idle > 0) begin
                sink_idle--;
                ready = 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                sink_idle = $urandom_range(1, 18) - 1;
                ready = 1'b0;
            end else begin
                ready = 1'b1;
            end
            m_tready <= ready;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------

    // APB write: setup edge, access edge, then release; update the register copy
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == dtf_pkg::REG_DECAY)
            cfg_decay = (value[dtf_pkg::DECAY_W-1:0] < dtf_pkg::DECAY_FLOOR)
                      ? dtf_pkg::DECAY_FLOOR : value[dtf_pkg::DECAY_W-1:0];
        else
            cfg_mode = value[dtf_pkg::MODE_W-1:0];
        @(negedge aclk);
    endtask

    // wait until every word is offered, taken and answered, then let the block settle
    task automatic wait_drained();
        while (target_queue.size() != 0 || s_tvalid || level_expect.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // queue random runs: a target held for a while so the follower can settle,
    // with some single noise words and some targets above full scale
    task automatic queue_runs(int count);
        logic [LEVEL_W-1:0] level;
        int                 run;
        int                 pick;
        while (count > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                level = LEVEL_W'($urandom_range(0, ONE_LEVEL));
            else if (pick < 8)
                level = ($urandom_range(0, 1) != 0) ? LEVEL_W'(ONE_LEVEL) : '0;
            else
                level = LEVEL_W'($urandom_range(ONE_LEVEL + 1, (1 << LEVEL_W) - 1));
            run = (pick == 9) ? 1 : $urandom_range(1, 24);
            for (int k = 0; k < run && count > 0; k++) begin
                target_queue.push_back(level);
                count--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [dtf_pkg::MODE_W-1:0]  mode_seq  [4];
        logic [dtf_pkg::DECAY_W-1:0] decay_seq [4];
        logic [dtf_pkg::DECAY_W-1:0] decay_pick;

        mode_seq     = '{dtf_pkg::MODE_SPRING, dtf_pkg::MODE_PROP,
                         dtf_pkg::MODE_DOUBLE3, dtf_pkg::MODE_DOUBLE0};
        decay_seq    = '{11'd25, 11'd2047, 11'd26, 11'd1024};
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        cycles       = 0;
        idle_enable  = 1'b1;
        src_pause    = 1'b0;
        hold_request = 1'b0;
        follow_pos   = 0;
        follow_vel   = VEL_START;
        cfg_decay    = dtf_pkg::DECAY_RESET;
        cfg_mode     = dtf_pkg::MODE_DOUBLE0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings first, full scale, above full scale, back to zero
        target_queue = '{15'd0, 15'd16384, 15'd16384, 15'd32767, 15'd0};
        wait_drained();

        // spring-damper with decay written as zero, raised to the floor
        write_reg({dtf_pkg::REG_MODE, 2'b00}, {30'h0, dtf_pkg::MODE_SPRING});
        write_reg({dtf_pkg::REG_DECAY, 2'b00}, 32'h0);
        target_queue = '{15'd16384, 15'd16384, 15'h2AAA, 15'h5555, 15'd0};
        wait_drained();

        // proportional at the largest decay: velocity saturates both ways
        write_reg({dtf_pkg::REG_MODE, 2'b00}, {30'h0, dtf_pkg::MODE_PROP});
        write_reg({dtf_pkg::REG_DECAY, 2'b00}, 32'd2047);
        target_queue = '{15'd32767, 15'd0, 15'd16384, 15'd1, 15'd0};
        wait_drained();

        // doubled gain, junk in the upper write bits must be dropped
        write_reg({dtf_pkg::REG_MODE, 2'b00}, {30'h3FFF_FFFF, dtf_pkg::MODE_DOUBLE3});
        write_reg({dtf_pkg::REG_DECAY, 2'b00}, 32'hFFFF_FC00 | 32'd1024);
        target_queue = '{15'd16384, 15'd8191, 15'd0, 15'd32767, 15'd16383};
        wait_drained();

        // random phases, each with its own decay and mode
        for (int p = 0; p < 8; p++) begin
            decay_pick = (p < 4) ? decay_seq[p]
                                 : dtf_pkg::DECAY_W'($urandom_range(0, 2047));
            write_reg({dtf_pkg::REG_DECAY, 2'b00},
                      {21'($urandom_range(0, 2097151)), decay_pick});
            write_reg({dtf_pkg::REG_MODE, 2'b00}, {30'($urandom()), mode_seq[p % 4]});
            if (p == 7)
                idle_enable = 1'b0;    // closing phase runs at full rate
            queue_runs(110);
            if (p == 2)
                hold_request = 1'b1;   // stall the result side while words keep coming
            if (p == 5) begin
                // pause the sender midway until every level is back
                while (target_queue.size() > 55)
                    @(negedge aclk);
                src_pause = 1'b1;
                while (s_tvalid || level_expect.size() != 0)
                    @(negedge aclk);
                src_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
sv/dtf_pkg.sv
sv/dtf_regs.sv
sv/dtf_mul.sv
sv/damped_target_follower.sv
dv/testbench.sv
